### sv/sha_pkg.sv
package sha_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_COMP,
    ST_FOLD,
    ST_EMIT
  } sha_state_t;

  typedef struct packed {
    logic       wr_byte;
    logic [7:0] wr_data;
    logic       len_add;
    logic       len_clr;
    logic       cnt_clr;
    logic       comp_start;
    logic       round_en;
    logic       fold;
    logic       h_init;
    logic       len_latch;
    logic       len_wr;
  } sha_cmd_t;

  typedef struct packed {
    logic [5:0] count;
    logic [5:0] round;
  } sha_stat_t;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage

### sv/sha_if.sv
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;
  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

### sv/sha_datapath.sv
module sha_datapath (
  input  logic               clk,
  input  logic               rst,
  input  sha_pkg::sha_cmd_t  cmd,
  output sha_pkg::sha_stat_t stat,
  input  logic [2:0]         rd_sel,
  output logic [31:0]        rd_word
);
  import sha_pkg::*;

  // block buffer as 16 big-endian words, one byte lane written per cycle
  logic [3:0][7:0] buf_w [16];
  logic [5:0]  count;
  logic [63:0] message_bits;
  logic [63:0] len_hold;
  logic [31:0] h [8];
  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [5:0]  round;
  logic [31:0] w_cur, w_new, s0, s1, t1, t2, big0, big1, ch, maj;

  always_ff @(posedge clk) begin
    if (cmd.wr_byte) begin
      buf_w[count[5:2]][~count[1:0]] <= cmd.wr_data;
    end else if (cmd.len_wr) begin
      buf_w[count[5:2]][~count[1:0]] <= len_hold[63:56];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.len_latch) begin
      len_hold <= message_bits;
    end else if (cmd.len_wr) begin
      len_hold <= {len_hold[55:0], 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      message_bits <= '0;
    end else begin
      if (cmd.cnt_clr) begin
        count <= '0;
      end else if (cmd.wr_byte || cmd.len_wr) begin
        count <= count + 6'd1;
      end
      if (cmd.len_clr) begin
        message_bits <= '0;
      end else if (cmd.len_add) begin
        message_bits <= message_bits + 64'd8;
      end
    end
  end

  // message schedule: 16-word window, rounds 0..15 read the buffer
  assign s0 = ror(w[1], 7) ^ ror(w[1], 18) ^ (w[1] >> 3);
  assign s1 = ror(w[14], 17) ^ ror(w[14], 19) ^ (w[14] >> 10);
  assign w_new = w[0] + s0 + w[9] + s1;
  assign w_cur = (round < 6'd16) ? buf_w[round[3:0]] : w_new;

  assign big1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
  assign ch   = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign t1   = v[7] + big1 + ch + ROUND_K[round] + w_cur;
  assign big0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
  assign maj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t2   = big0 + maj;

  always_ff @(posedge clk) begin
    if (rst) begin
      round <= '0;
    end else if (cmd.comp_start) begin
      round <= '0;
    end else if (cmd.round_en) begin
      round <= round + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.comp_start) begin
      v <= h;
    end else if (cmd.round_en) begin
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= w_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.h_init) begin
      h <= INIT_H;
    end else if (cmd.fold) begin
      for (int i = 0; i < 8; i++) begin
        h[i] <= h[i] + v[i];
      end
    end
  end

  assign rd_word = h[rd_sel];
  assign stat.count = count;
  assign stat.round = round;
endmodule

### sv/sha_ctrl.sv
module sha_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic [7:0]         in_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_index,
  output sha_pkg::sha_cmd_t  cmd,
  input  sha_pkg::sha_stat_t stat
);
  import sha_pkg::*;

  sha_state_t state, state_next;
  logic       finishing;
  logic       final_block;
  logic [2:0] idx;
  logic       acc;

  assign acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      finishing   <= 1'b0;
      final_block <= 1'b0;
      idx         <= '0;
    end else begin
      state <= state_next;
      if (acc) begin
        finishing   <= (in_cmd == CMD_FINISH);
        // pad byte lands at 55: length fits right behind it
        final_block <= (in_cmd == CMD_FINISH) && (stat.count == 6'd55);
      end
      if (state == ST_PAD && stat.count == 6'd55) begin
        final_block <= 1'b1;
      end
      if (state == ST_EMIT && out_ready) begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          if (stat.count == 6'd63) begin
            state_next = ST_COMP;
          end else if (in_cmd == CMD_FINISH) begin
            state_next = (stat.count == 6'd55) ? ST_LEN : ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (stat.count == 6'd55) begin
          state_next = ST_LEN;
        end else if (stat.count == 6'd63) begin
          state_next = ST_COMP;
        end
      end
      ST_LEN:  if (stat.count == 6'd63) state_next = ST_COMP;
      ST_COMP: if (stat.round == 6'd63) state_next = ST_FOLD;
      ST_FOLD: begin
        if (!finishing) begin
          state_next = ST_IDLE;
        end else if (final_block) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_PAD;
        end
      end
      ST_EMIT: if (out_ready && idx == 3'd7) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.wr_byte    = acc;
        cmd.wr_data    = (in_cmd == CMD_FINISH) ? PAD_BYTE : in_byte;
        cmd.len_add    = acc && (in_cmd == CMD_ABSORB);
        cmd.len_latch  = acc;
        cmd.comp_start = acc && stat.count == 6'd63;
      end
      ST_PAD: begin
        cmd.wr_byte    = 1'b1;
        cmd.wr_data    = 8'h00;
        cmd.comp_start = (stat.count == 6'd63);
      end
      ST_LEN: begin
        cmd.len_wr     = 1'b1;
        cmd.comp_start = (stat.count == 6'd63);
      end
      ST_COMP: cmd.round_en = 1'b1;
      ST_FOLD: cmd.fold = 1'b1;
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready && idx == 3'd7) begin
          cmd.h_init  = 1'b1;
          cmd.len_clr = 1'b1;
          cmd.cnt_clr = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_index = idx;
endmodule

### sv/sha256_stream_hasher.sv
// SHA-256 stream hasher: one message byte per absorb request.
// Absorb: every 64th byte starts a compression (64 rounds, fold) before the next byte.
// Finish: pads byte by byte, runs 1 or 2 compressions, then 8 digest words,
// one per cycle while the sink is ready.
// One item in flight; input ready only while the controller is idle.
// Reset (rst, synchronous): initial hash values, empty buffer, zero length.
module sha256_stream_hasher (
  input logic clk,
  input logic rst,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch
);
  import sha_pkg::*;

  sha_cmd_t  cmd;
  sha_stat_t stat;
  logic [2:0] idx;
  logic [31:0] word;

  // Sequencer: absorb, padding, length, rounds, fold, digest emission.
  sha_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_cmd(in_ch.cmd), .in_byte(in_ch.data_byte),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_index(idx), .cmd(cmd), .stat(stat)
  );

  // Block buffer, length counter, schedule window and round unit.
  sha_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .rd_sel(idx), .rd_word(word)
  );

  assign out_ch.digest_word = word;
  assign out_ch.word_index  = idx;
  assign out_ch.last_word   = (idx == 3'd7);
endmodule
